[rtl/core/vector_magnitude_3d_scaled_macros.svh]
// ---------------------------------------------------------------------------
// vector magnitude assertion macros
// shared assertion forms, sampled on clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef VECTOR_MAGNITUDE_3D_SCALED_MACROS_SVH
`define VECTOR_MAGNITUDE_3D_SCALED_MACROS_SVH

// same-cycle implication
`define VM3S_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VM3S_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/vm3s_pkg.sv]
// ---------------------------------------------------------------------------
// vm3s_pkg
// types, widths and helpers for the scaled 3d vector magnitude block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package vm3s_pkg;

	localparam int unsigned CompW  = 32;
	localparam int unsigned AbsW   = 30;
	localparam int unsigned ProdW  = 2 * AbsW;
	localparam int unsigned RootW  = AbsW;
	localparam int unsigned RemW   = 32;
	localparam int unsigned IterW  = 5;
	localparam int unsigned ShiftW = 2;
	localparam int unsigned InDataW  = 3 * CompW;
	localparam int unsigned OutDataW = 32;

	localparam logic [CompW-1:0] FIT_BIAS  = 32'hE000_0000;
	localparam logic [CompW-1:0] FIT_LIMIT = 32'hBFFF_FFFF;

	localparam logic [IterW-1:0] ROOT_LAST_ITER = IterW'(RootW - 1);

	typedef logic signed [CompW-1:0] comp_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCALE = 5'b00010,
		ST_SQ    = 5'b00100,
		ST_ROOT  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// component lies in [-2^29, 2^29)
	function automatic logic in_range(input comp_t v);
		logic [CompW-1:0] t;
		t = CompW'(v) + FIT_BIAS;
		return t > FIT_LIMIT;
	endfunction

	function automatic comp_t asr1(input comp_t v);
		return v >>> 1;
	endfunction

	// magnitude of an in-range component
	function automatic logic [AbsW-1:0] abs_val(input comp_t v);
		logic [CompW-1:0] a;
		a = v[CompW-1] ? (~CompW'(v) + CompW'(1)) : CompW'(v);
		return a[AbsW-1:0];
	endfunction

endpackage

[rtl/core/vector_magnitude_3d_scaled.sv]
// ---------------------------------------------------------------------------
// vector_magnitude_3d_scaled
// scaled integer magnitude of a signed 3d vector
//
// s_tdata carries one request: comp_x [31:0], comp_y [63:32], comp_z [95:64].
// m_tdata carries the result: magnitude [31:0].
// components are shifted right (0 to 2 places) until all lie in [-2^29, 2^29),
// the floor square root of the sum of squares is taken and shifted back.
// a request passes from acceptance to the result register through the scaling
// steps, the shared 30x30 multiplier, the bit-per-cycle root loop and the load
// of the output register; the next request is only taken after that load, once
// the sequencer is back in idle.
// s_tready is high only while the sequencer is idle, so a new request can be
// accepted while the previous result still waits in the output register.
// if the receiver stalls, the finished root waits until that register frees.
// reset clears the sequencer and the output valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vector_magnitude_3d_scaled_macros.svh"

module vector_magnitude_3d_scaled (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [vm3s_pkg::InDataW-1:0]     s_tdata,   // comp_x, comp_y, comp_z
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [vm3s_pkg::OutDataW-1:0]    m_tdata    // magnitude
);

	import vm3s_pkg::*;

	state_t            state_q;
	comp_t             x_q, y_q, z_q;
	logic [ShiftW-1:0] shift_q;
	logic [1:0]        sq_cnt_q;
	logic [ProdW-1:0]  prod_q;
	logic [ProdW-1:0]  sum_q;
	logic [IterW-1:0]  iter_q;
	logic [RemW-1:0]   rem_q;
	logic [RootW-1:0]  root_q;
	logic              m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;

	logic              all_in;
	logic              s_acc;
	logic              out_free;
	logic              root_last;
	comp_t             sq_sel;
	logic [AbsW-1:0]   sq_abs;
	logic [RemW+1:0]   rem_cat;
	logic [RemW+1:0]   trial;
	logic              ge;
	logic [RemW+1:0]   rem_diff;
	logic [RootW-1:0]  root_nxt;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign root_last = (state_q == ST_ROOT) && (iter_q == ROOT_LAST_ITER);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign all_in = in_range(x_q) && in_range(y_q) && in_range(z_q);

	always_comb begin
		case (sq_cnt_q)
			2'd0:    sq_sel = x_q;
			2'd1:    sq_sel = y_q;
			default: sq_sel = z_q;
		endcase
	end
	assign sq_abs = abs_val(sq_sel);

	// one root bit per cycle, two radicand bits brought down each step
	assign rem_cat  = {rem_q, sum_q[ProdW-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign ge       = rem_cat >= trial;
	assign rem_diff = ge ? (rem_cat - trial) : rem_cat;
	assign root_nxt = {root_q[RootW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_acc)
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (all_in)
						state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (sq_cnt_q == 2'd3)
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					x_q      <= comp_t'(s_tdata[CompW-1:0]);
					y_q      <= comp_t'(s_tdata[2*CompW-1:CompW]);
					z_q      <= comp_t'(s_tdata[3*CompW-1:2*CompW]);
					shift_q  <= '0;
					sq_cnt_q <= '0;
					sum_q    <= '0;
					iter_q   <= '0;
					rem_q    <= '0;
					root_q   <= '0;
				end
			end
			ST_SCALE: begin
				if (!all_in) begin
					x_q     <= asr1(x_q);
					y_q     <= asr1(y_q);
					z_q     <= asr1(z_q);
					shift_q <= shift_q + ShiftW'(1);
				end
			end
			ST_SQ: begin
				// multiplier output registered, accumulated into the sum in the next cycle
				if (sq_cnt_q != 2'd3)
					prod_q <= ProdW'(sq_abs) * ProdW'(sq_abs);
				if (sq_cnt_q != 2'd0)
					sum_q <= sum_q + prod_q;
				sq_cnt_q <= sq_cnt_q + 2'd1;
			end
			ST_ROOT: begin
				rem_q  <= rem_diff[RemW-1:0];
				root_q <= root_nxt;
				sum_q  <= {sum_q[ProdW-3:0], 2'b00};
				iter_q <= iter_q + IterW'(1);
			end
			ST_DONE: begin
				if (out_free)
					m_tdata_q <= OutDataW'({2'b00, root_q} << shift_q);
			end
			default: begin
			end
		endcase
	end

	`VM3S_ASSERT_NEXT(a_accept_scales, s_acc, state_q == ST_SCALE, "request did not start scaling")
	`VM3S_ASSERT_NOW(a_shift_bound, state_q != ST_IDLE, shift_q <= ShiftW'(2), "shift above two")
	`VM3S_ASSERT_NOW(a_sq_in_range, state_q == ST_SQ, all_in, "component out of range at squaring")
	`VM3S_ASSERT_NEXT(a_root_ends, root_last, state_q == ST_DONE, "root loop overran")

endmodule

[verif/vector_magnitude_3d_scaled_tb.sv]
// ---------------------------------------------------------------------------
// vector_magnitude_3d_scaled_tb
// self-checking bench for the scaled 3d vector magnitude block: a directed
// table of corner vectors, then random vectors biased towards the range
// boundaries, with random gaps on the request side and random stalls on the
// result side; results checked against the table or an in-bench integer model
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_magnitude_3d_scaled_tb;

	import vm3s_pkg::*;

	localparam int unsigned NumRandom = 1600;
	localparam int unsigned IdleLimit = 3000;
	localparam int unsigned DrainWait = 60;
	localparam int unsigned NumRows   = 21;

	typedef struct packed {
		logic [CompW-1:0]    x;
		logic [CompW-1:0]    y;
		logic [CompW-1:0]    z;
		logic                known;
		logic [OutDataW-1:0] mag;
	} vec_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;

	logic [OutDataW-1:0] mag_q[$];
	logic [OutDataW-1:0] mag_exp;
	logic                row_known;
	logic [OutDataW-1:0] row_mag;
	int unsigned         errors;
	int unsigned         idle_cycles;
	bit                  calm;
	vec_row_t            dir_tbl [NumRows];

	vector_magnitude_3d_scaled u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit comp_fits(input logic [CompW-1:0] v);
		logic [CompW-1:0] t;
		t = v + FIT_BIAS;
		return t > FIT_LIMIT;
	endfunction

	function automatic logic [63:0] comp_square(input logic [CompW-1:0] v);
		logic [63:0] a;
		a = v[CompW-1] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
		return a * a;
	endfunction

	// exact floor root of the scaled sum of squares, shifted back and wrapped
	function automatic logic [OutDataW-1:0] scaled_magnitude(input logic [CompW-1:0] cx,
			input logic [CompW-1:0] cy, input logic [CompW-1:0] cz);
		int unsigned shift;
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] probe;
		logic [63:0] back;
		shift = 0;
		while (shift < 32 && !(comp_fits(cx) && comp_fits(cy) && comp_fits(cz))) begin
			shift++;
			cx = {cx[CompW-1], cx[CompW-1:1]};
			cy = {cy[CompW-1], cy[CompW-1:1]};
			cz = {cz[CompW-1], cz[CompW-1:1]};
		end
		rem   = comp_square(cx) + comp_square(cy) + comp_square(cz);
		root  = '0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		back = root << (shift & 31);
		return back[OutDataW-1:0];
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		if (r < 98)
			return $urandom_range(5, 20);
		return $urandom_range(40, 120);
	endfunction

	// biased towards the edges of the fitting range and the extremes
	function automatic logic [CompW-1:0] rand_comp();
		int unsigned      sel;
		logic [CompW-1:0] edge_val;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: begin
				return $urandom;
			end
			4, 5: begin
				return CompW'($urandom_range(0, 2000)) - 32'd1000;
			end
			6: begin
				case ($urandom_range(0, 6))
					0: edge_val = 32'h2000_0000;
					1: edge_val = 32'hE000_0000;
					2: edge_val = 32'h4000_0000;
					3: edge_val = 32'hC000_0000;
					4: edge_val = 32'h8000_0000;
					5: edge_val = 32'h7FFF_FFFF;
					default: edge_val = 32'h0000_0000;
				endcase
				return edge_val + CompW'($urandom_range(0, 4)) - 32'd2;
			end
			7: begin
				return '0;
			end
			default: begin
				return ($urandom & 32'h3FFF_FFFF) - 32'h2000_0000;
			end
		endcase
	endfunction

	task automatic send_vec(input logic [CompW-1:0] cx, input logic [CompW-1:0] cy,
			input logic [CompW-1:0] cz, input logic known, input logic [OutDataW-1:0] kmag);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {cz, cy, cx};
		row_known = known;
		row_mag   = kmag;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// result side: bursts of ready, stalls mostly short and now and then long
	initial begin : result_sink
		int unsigned run;
		m_tready <= 1'b0;
		run = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				m_tready <= 1'b1;
				run = 0;
			end else if (run == 0) begin
				if (m_tready == 1'b0 || $urandom_range(0, 2) == 0) begin
					m_tready <= 1'b1;
					run = $urandom_range(1, 30);
				end else begin
					m_tready <= 1'b0;
					run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
						: $urandom_range(1, 5);
				end
			end else begin
				run--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				mag_q.push_back(row_known ? row_mag : scaled_magnitude(s_tdata[31:0],
					s_tdata[63:32], s_tdata[95:64]));
			if (m_tvalid && m_tready) begin
				if (mag_q.size() == 0) begin
					$display("%0t: unexpected magnitude: expected none, actual %h",
						$time, m_tdata);
					errors++;
				end else begin
					mag_exp = mag_q.pop_front();
					if (m_tdata !== mag_exp) begin
						$display("%0t: magnitude mismatch: expected %h, actual %h",
							$time, mag_exp, m_tdata);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CompW-1:0] rx;
		logic [CompW-1:0] ry;
		logic [CompW-1:0] rz;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		row_known   = 1'b0;
		row_mag     = '0;
		errors      = 0;
		idle_cycles = 0;
		calm        = 1'b0;

		dir_tbl = '{
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'd0},
			'{32'd3,         32'd4,         32'h0000_0000, 1'b1, 32'd5},
			'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFF9, 1'b1, 32'd7},
			'{32'd1,         32'h0000_0000, 32'h0000_0000, 1'b1, 32'd1},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1},
			'{32'h1FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h1FFF_FFFF},
			'{32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h2000_0000},
			'{32'h2000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h2000_0000},
			'{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
			'{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFC},
			'{32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h4000_0000},
			'{32'hC000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h4000_0000},
			'{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
			'{32'd300000000, 32'd400000000, 32'h0000_0000, 1'b1, 32'd500000000},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'd0},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'd0},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd0},
			'{32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0},
			'{32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 1'b0, 32'd0},
			'{32'hE000_0000, 32'h1FFF_FFFF, 32'hDFFF_FFFF, 1'b0, 32'd0},
			'{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0, 32'd0}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NumRows; i++)
			send_vec(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z, dir_tbl[i].known,
				dir_tbl[i].mag);

		for (int n = 0; n < NumRandom; n++) begin
			// every hundred requests, now and then a stretch with no idling
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			rx = rand_comp();
			ry = rand_comp();
			rz = rand_comp();
			case ($urandom_range(0, 19))
				0, 1: rz = '0;
				2: begin
					ry = rx;
					rz = rx;
				end
				default: ;
			endcase
			send_vec(rx, ry, rz, 1'b0, '0);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (mag_q.size() != 0)
			@(posedge clk);
		repeat (DrainWait) @(posedge clk);

		if (errors == 0 && mag_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
